>>> sv/vrt_pkg.sv
`default_nettype none
package vrt_pkg;

    localparam int GRID_AXIS_BITS_DEF = 5;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam int ORIGIN_W   = 24;
    localparam int DIR_W      = 16;
    localparam int DIST_W     = 24;
    localparam int VOXEL_W    = 5;
    localparam int CELL_OUT_W = 9;
    localparam int FACE_W     = 3;
    localparam int AXES       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] SKIP_Q32 = 64'd4294967;
    localparam logic [63:0] INF_Q32  = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_CAST,
        KIND_MISS
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEN,
        ST_SQRT,
        ST_DIV,
        ST_READ,
        ST_EVAL,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef struct packed {
        kind_t                          kind;
        logic [VOXEL_W-1:0]             voxel_x;
        logic [VOXEL_W-1:0]             voxel_y;
        logic [VOXEL_W-1:0]             voxel_z;
        logic                           voxel_solid;
        logic [AXES-1:0][ORIGIN_W-1:0]  origin;
        logic [AXES-1:0][DIR_W-1:0]     dir;
        logic [DIST_W-1:0]              max_distance;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

>>> sv/vrt_front.sv
`default_nettype none
module vrt_front (
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           command,
    input  wire logic [vrt_pkg::VOXEL_W-1:0]    voxel_x,
    input  wire logic [vrt_pkg::VOXEL_W-1:0]    voxel_y,
    input  wire logic [vrt_pkg::VOXEL_W-1:0]    voxel_z,
    input  wire logic                           voxel_solid,
    input  wire logic [vrt_pkg::ORIGIN_W-1:0]   origin_x,
    input  wire logic [vrt_pkg::ORIGIN_W-1:0]   origin_y,
    input  wire logic [vrt_pkg::ORIGIN_W-1:0]   origin_z,
    input  wire logic [vrt_pkg::DIR_W-1:0]      dir_x,
    input  wire logic [vrt_pkg::DIR_W-1:0]      dir_y,
    input  wire logic [vrt_pkg::DIR_W-1:0]      dir_z,
    input  wire logic [vrt_pkg::DIST_W-1:0]     max_distance,
    input  wire logic                           clearing,
    input  wire logic                           q_full,
    output logic                                push,
    output vrt_pkg::item_t                      item
);
    import vrt_pkg::*;

    logic nz_x, nz_y, nz_z;
    logic unit_x, unit_y, unit_z;
    logic short_dir;

    assign nz_x   = dir_x != '0;
    assign nz_y   = dir_y != '0;
    assign nz_z   = dir_z != '0;
    assign unit_x = (dir_x == DIR_W'(1)) || (dir_x == '1);
    assign unit_y = (dir_y == DIR_W'(1)) || (dir_y == '1);
    assign unit_z = (dir_z == DIR_W'(1)) || (dir_z == '1);

    // squared length below three: at most two unit components
    assign short_dir = (!nz_x || unit_x) && (!nz_y || unit_y) && (!nz_z || unit_z)
                       && !(nz_x && nz_y && nz_z);

    assign in_stall = q_full || clearing;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        item.voxel_x      = voxel_x;
        item.voxel_y      = voxel_y;
        item.voxel_z      = voxel_z;
        item.voxel_solid  = voxel_solid;
        item.origin       = {origin_z, origin_y, origin_x};
        item.dir          = {dir_z, dir_y, dir_x};
        item.max_distance = max_distance;
        priority if (command == CMD_WRITE)
        begin
            item.kind = KIND_WRITE;
        end
        else if (short_dir)
        begin
            item.kind = KIND_MISS;
        end
        else
        begin
            item.kind = KIND_CAST;
        end
    end

endmodule
`default_nettype wire

>>> sv/vrt_queue.sv
`default_nettype none
module vrt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  vrt_pkg::item_t      item_in,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output vrt_pkg::item_t      item_out
);
    import vrt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;

    assign full     = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign item_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule
`default_nettype wire

>>> sv/vrt_divider.sv
`default_nettype none
module vrt_divider (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  vrt_pkg::div_req_t   req,
    output vrt_pkg::div_rsp_t   rsp
);
    import vrt_pkg::*;

    localparam int NUM_W  = 64;
    localparam int DEN_W  = 32;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg, done_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W:0]     shifted;
    logic               fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_comb
    begin
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        if (req.start)
        begin
            count_next = CNT_W'(NUM_W);
            rem_next   = '0;
            quo_next   = req.num;
            den_next   = req.den;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            done_next  = count_reg == CNT_W'(1);
            rem_next   = fits ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
            quo_next   = {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule
`default_nettype wire

>>> sv/vrt_back.sv
`default_nettype none
module vrt_back #(
    parameter int GRID_AXIS_BITS = vrt_pkg::GRID_AXIS_BITS_DEF,
    parameter int FRACTION_BITS  = vrt_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_empty,
    input  vrt_pkg::item_t                          q_item,
    output logic                                    q_pop,
    output logic                                    clearing,
    output vrt_pkg::div_req_t                       div_req,
    input  vrt_pkg::div_rsp_t                       div_rsp,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    hit,
    output logic signed [vrt_pkg::CELL_OUT_W-1:0]   cell_x,
    output logic signed [vrt_pkg::CELL_OUT_W-1:0]   cell_y,
    output logic signed [vrt_pkg::CELL_OUT_W-1:0]   cell_z,
    output logic [vrt_pkg::DIST_W-1:0]              hit_distance,
    output logic signed [vrt_pkg::ORIGIN_W-1:0]     point_x,
    output logic signed [vrt_pkg::ORIGIN_W-1:0]     point_y,
    output logic signed [vrt_pkg::ORIGIN_W-1:0]     point_z,
    output logic [vrt_pkg::FACE_W-1:0]              entry_face
);
    import vrt_pkg::*;

    localparam int G         = GRID_AXIS_BITS;
    localparam int F         = FRACTION_BITS;
    localparam int ADDR_W    = 3 * G;
    localparam int CELLS     = 1 << ADDR_W;
    localparam int SIZE      = 1 << G;
    localparam int CELL_W    = (25 - F > G + 2) ? 25 - F : G + 2;
    localparam int SHIFT_LIM = 32 - F;
    localparam int SHIFT_B   = 62 - F;
    localparam int BW        = F + 1;
    localparam int CNT_W     = 5;
    localparam logic [CNT_W-1:0] LEN_LAST  = CNT_W'(AXES - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(3 * AXES - 1);
    localparam logic [CNT_W-1:0] PT_LAST   = CNT_W'(AXES - 1);
    localparam logic [1:0] PH_UNIT  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_SPAN  = 2'd2;
    localparam logic [BW-1:0] ONE_CELL = BW'(1) << F;
    localparam logic signed [CELL_W-1:0] SIZE_C = CELL_W'(SIZE);
    localparam logic signed [27:0] SAT_HI = 28'sd8388607;
    localparam logic signed [27:0] SAT_LO = -28'sd8388608;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clear_cnt_reg, clear_cnt_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   div_wait_reg, div_wait_next;
    logic                   out_valid_reg, out_valid_next;

    item_t                  item_reg, item_next;
    logic [31:0]            len2_reg, len2_next;
    logic [63:0]            sq_v_reg, sq_v_next;
    logic [33:0]            sq_rem_reg, sq_rem_next;
    logic [31:0]            sq_root_reg, sq_root_next;
    logic [31:0]            u_reg [AXES];
    logic [31:0]            u_next [AXES];
    logic [63:0]            nc_reg [AXES];
    logic [63:0]            nc_next [AXES];
    logic [63:0]            span_reg [AXES];
    logic [63:0]            span_next [AXES];
    logic signed [CELL_W-1:0] cell_reg [AXES];
    logic signed [CELL_W-1:0] cell_next [AXES];
    logic [63:0]            dist_reg, dist_next;
    logic [63:0]            limit_reg, limit_next;
    logic [FACE_W-1:0]      face_reg, face_next;
    logic [1:0]             axis_reg, axis_next;
    logic                   in_grid_reg, in_grid_next;
    logic                   escape_reg, escape_next;
    logic                   res_hit_reg, res_hit_next;
    logic [DIST_W-1:0]      hit_dist_reg, hit_dist_next;
    logic [55:0]            prod_reg, prod_next;
    logic signed [ORIGIN_W-1:0] point_reg [AXES];
    logic signed [ORIGIN_W-1:0] point_next [AXES];

    logic                   hit_reg, hit_next;
    logic signed [CELL_OUT_W-1:0] cell_x_reg, cell_x_next;
    logic signed [CELL_OUT_W-1:0] cell_y_reg, cell_y_next;
    logic signed [CELL_OUT_W-1:0] cell_z_reg, cell_z_next;
    logic [DIST_W-1:0]      hit_distance_reg, hit_distance_next;
    logic signed [ORIGIN_W-1:0] point_x_reg, point_x_next;
    logic signed [ORIGIN_W-1:0] point_y_reg, point_y_next;
    logic signed [ORIGIN_W-1:0] point_z_reg, point_z_next;
    logic [FACE_W-1:0]      entry_face_reg, entry_face_next;

    logic                   grid_mem [CELLS];
    logic                   mem_rdata_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic                   mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;

    logic [35:0]            sq_shift;
    logic [35:0]            sq_trial;
    logic [1:0]             div_phase;
    logic [1:0]             div_axis;
    logic                   div_neg;
    logic                   div_skip;
    logic                   div_step_done;
    logic [15:0]            div_mag;
    logic [F-1:0]           div_frac;
    logic [BW-1:0]          div_b;
    logic                   past_limit;
    logic                   eval_hit;
    logic                   eval_miss;
    logic                   out_free;
    logic [1:0]             pick;
    logic [AXES-1:0]        axis_in;
    logic [AXES-1:0]        axis_gone;
    logic                   step_neg;
    logic [63:0]            nc_step;
    logic [63:0]            nc_room;
    logic [31:0]            sq_term;
    logic signed [27:0]     pt_sum;
    logic [27:0]            pt_mag;

    assign clearing  = state_reg == ST_CLEAR;
    assign out_free  = !out_valid_reg || !out_stall;
    assign mem_raddr = {cell_reg[0][G-1:0], cell_reg[1][G-1:0], cell_reg[2][G-1:0]};

    assign sq_shift  = {sq_rem_reg, sq_v_reg[63:62]};
    assign sq_trial  = {2'b00, sq_root_reg, 2'b01};
    assign sq_term   = 32'($signed(item_reg.dir[cnt_reg[1:0]])
                           * $signed(item_reg.dir[cnt_reg[1:0]]));

    always_comb
    begin
        priority if (cnt_reg >= CNT_W'(2 * AXES))
        begin
            div_phase = PH_SPAN;
            div_axis  = 2'(cnt_reg - CNT_W'(2 * AXES));
        end
        else if (cnt_reg >= CNT_W'(AXES))
        begin
            div_phase = PH_FIRST;
            div_axis  = 2'(cnt_reg - CNT_W'(AXES));
        end
        else
        begin
            div_phase = PH_UNIT;
            div_axis  = 2'(cnt_reg);
        end
    end

    assign div_neg  = item_reg.dir[div_axis][DIR_W-1];
    assign div_mag  = div_neg ? 16'(~item_reg.dir[div_axis] + 1'b1) : item_reg.dir[div_axis];
    assign div_frac = item_reg.origin[div_axis][F-1:0];
    assign div_b    = div_neg ? {1'b0, div_frac} : ONE_CELL - {1'b0, div_frac};
    assign div_skip = (div_phase != PH_UNIT) && (u_reg[div_axis] == '0);
    assign div_step_done = div_wait_reg ? div_rsp.done : div_skip;

    always_comb
    begin
        div_req.start = (state_reg == ST_DIV) && !div_wait_reg && !div_skip;
        unique case (div_phase)
            PH_UNIT:
            begin
                div_req.num = 64'(div_mag) << 46;
                div_req.den = sq_root_reg;
            end
            PH_FIRST:
            begin
                div_req.num = 64'(div_b) << SHIFT_B;
                div_req.den = u_reg[div_axis];
            end
            default:
            begin
                div_req.num = 64'h4000_0000_0000_0000;
                div_req.den = u_reg[div_axis];
            end
        endcase
    end

    always_comb
    begin
        priority if (nc_reg[0] < nc_reg[1] && nc_reg[0] < nc_reg[2])
        begin
            pick = 2'd0;
        end
        else if (nc_reg[1] < nc_reg[2])
        begin
            pick = 2'd1;
        end
        else
        begin
            pick = 2'd2;
        end
    end

    for (genvar k = 0; k < AXES; k++)
    begin : g_axis
        assign axis_in[k]   = (cell_reg[k] >= 0) && (cell_reg[k] < SIZE_C);
        assign axis_gone[k] = !axis_in[k] && ((u_reg[k] == '0)
                              || (item_reg.dir[k][DIR_W-1] ? (cell_reg[k] < 0)
                                                           : (cell_reg[k] >= SIZE_C)));
    end

    assign past_limit = dist_reg >= limit_reg;
    assign eval_hit   = !past_limit && (dist_reg > SKIP_Q32) && in_grid_reg && mem_rdata_reg;
    assign eval_miss  = past_limit || (!eval_hit && escape_reg);
    assign step_neg   = item_reg.dir[axis_reg][DIR_W-1];
    assign nc_room    = INF_Q32 - span_reg[axis_reg];
    assign nc_step    = (nc_reg[axis_reg] > nc_room) ? INF_Q32
                                                     : nc_reg[axis_reg] + span_reg[axis_reg];

    assign pt_mag = {2'b00, prod_reg[55:30]};
    assign pt_sum = item_reg.dir[cnt_reg[1:0]][DIR_W-1]
                  ? 28'($signed(item_reg.origin[cnt_reg[1:0]])) - $signed(pt_mag)
                  : 28'($signed(item_reg.origin[cnt_reg[1:0]])) + $signed(pt_mag);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_item.kind)
                        KIND_CAST: state_next = ST_LEN;
                        KIND_MISS: state_next = ST_DONE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LEN:
            begin
                if (cnt_reg == LEN_LAST)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_step_done && cnt_reg == DIV_LAST)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                priority if (eval_miss)
                begin
                    state_next = ST_DONE;
                end
                else if (eval_hit)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = (cnt_reg == PT_LAST) ? ST_DONE : ST_MUL;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clear_cnt_next = clear_cnt_reg;
        cnt_next       = cnt_reg;
        div_wait_next  = div_wait_reg;
        out_valid_next = out_valid_reg && out_stall;
        item_next      = item_reg;
        len2_next      = len2_reg;
        sq_v_next      = sq_v_reg;
        sq_rem_next    = sq_rem_reg;
        sq_root_next   = sq_root_reg;
        u_next         = u_reg;
        nc_next        = nc_reg;
        span_next      = span_reg;
        cell_next      = cell_reg;
        dist_next      = dist_reg;
        limit_next     = limit_reg;
        face_next      = face_reg;
        axis_next      = axis_reg;
        in_grid_next   = in_grid_reg;
        escape_next    = escape_reg;
        res_hit_next   = res_hit_reg;
        hit_dist_next  = hit_dist_reg;
        prod_next      = prod_reg;
        point_next     = point_reg;
        hit_next          = hit_reg;
        cell_x_next       = cell_x_reg;
        cell_y_next       = cell_y_reg;
        cell_z_next       = cell_z_reg;
        hit_distance_next = hit_distance_reg;
        point_x_next      = point_x_reg;
        point_y_next      = point_y_reg;
        point_z_next      = point_z_reg;
        entry_face_next   = entry_face_reg;
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clear_cnt_reg;
        mem_wdata = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we         = 1'b1;
                clear_cnt_next = clear_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    item_next    = q_item;
                    cnt_next     = '0;
                    len2_next    = '0;
                    res_hit_next = 1'b0;
                    for (int k = 0; k < AXES; k++)
                    begin
                        cell_next[k] = CELL_W'($signed(q_item.origin[k]) >>> F);
                    end
                    if (q_item.kind == KIND_WRITE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {G'(q_item.voxel_x), G'(q_item.voxel_y),
                                     G'(q_item.voxel_z)};
                        mem_wdata = q_item.voxel_solid;
                    end
                end
            end
            ST_LEN:
            begin
                len2_next = len2_reg + sq_term;
                if (cnt_reg == LEN_LAST)
                begin
                    sq_v_next    = {len2_reg + sq_term, 32'd0};
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT:
            begin
                sq_v_next = {sq_v_reg[61:0], 2'b00};
                if (sq_shift >= sq_trial)
                begin
                    sq_rem_next  = 34'(sq_shift - sq_trial);
                    sq_root_next = {sq_root_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_next  = 34'(sq_shift);
                    sq_root_next = {sq_root_reg[30:0], 1'b0};
                end
                cnt_next      = (cnt_reg == SQRT_LAST) ? '0 : cnt_reg + 1'b1;
                div_wait_next = 1'b0;
            end
            ST_DIV:
            begin
                if (div_req.start)
                begin
                    div_wait_next = 1'b1;
                end
                if (div_step_done)
                begin
                    div_wait_next = 1'b0;
                    unique case (div_phase)
                        PH_UNIT:  u_next[div_axis]    = div_rsp.quotient[31:0];
                        PH_FIRST: nc_next[div_axis]   = div_skip ? INF_Q32 : div_rsp.quotient;
                        default:  span_next[div_axis] = div_skip ? INF_Q32 : div_rsp.quotient;
                    endcase
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        dist_next  = '0;
                        limit_next = 64'(item_reg.max_distance) << SHIFT_LIM;
                    end
                end
            end
            ST_READ:
            begin
                axis_next    = pick;
                in_grid_next = &axis_in;
                escape_next  = |axis_gone;
            end
            ST_EVAL:
            begin
                priority if (eval_miss)
                begin
                    res_hit_next = 1'b0;
                end
                else if (eval_hit)
                begin
                    res_hit_next  = 1'b1;
                    hit_dist_next = DIST_W'(dist_reg >> SHIFT_LIM);
                    cnt_next      = '0;
                end
                else
                begin
                    dist_next           = nc_reg[axis_reg];
                    nc_next[axis_reg]   = nc_step;
                    cell_next[axis_reg] = step_neg ? cell_reg[axis_reg] - CELL_W'(1)
                                                   : cell_reg[axis_reg] + CELL_W'(1);
                    face_next           = {axis_reg, step_neg};
                end
            end
            ST_MUL:
            begin
                prod_next = 56'(u_reg[cnt_reg[1:0]] * hit_dist_reg);
            end
            ST_ADD:
            begin
                priority if (pt_sum > SAT_HI)
                begin
                    point_next[cnt_reg[1:0]] = ORIGIN_W'(SAT_HI);
                end
                else if (pt_sum < SAT_LO)
                begin
                    point_next[cnt_reg[1:0]] = ORIGIN_W'(SAT_LO);
                end
                else
                begin
                    point_next[cnt_reg[1:0]] = ORIGIN_W'(pt_sum);
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    hit_next          = res_hit_reg;
                    cell_x_next       = res_hit_reg ? CELL_OUT_W'(cell_reg[0]) : '0;
                    cell_y_next       = res_hit_reg ? CELL_OUT_W'(cell_reg[1]) : '0;
                    cell_z_next       = res_hit_reg ? CELL_OUT_W'(cell_reg[2]) : '0;
                    hit_distance_next = res_hit_reg ? hit_dist_reg : '0;
                    point_x_next      = res_hit_reg ? point_reg[0] : '0;
                    point_y_next      = res_hit_reg ? point_reg[1] : '0;
                    point_z_next      = res_hit_reg ? point_reg[2] : '0;
                    entry_face_next   = res_hit_reg ? face_reg : '0;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            cnt_reg       <= '0;
            div_wait_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            cnt_reg       <= cnt_next;
            div_wait_reg  <= div_wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        len2_reg     <= len2_next;
        sq_v_reg     <= sq_v_next;
        sq_rem_reg   <= sq_rem_next;
        sq_root_reg  <= sq_root_next;
        u_reg        <= u_next;
        nc_reg       <= nc_next;
        span_reg     <= span_next;
        cell_reg     <= cell_next;
        dist_reg     <= dist_next;
        limit_reg    <= limit_next;
        face_reg     <= face_next;
        axis_reg     <= axis_next;
        in_grid_reg  <= in_grid_next;
        escape_reg   <= escape_next;
        res_hit_reg  <= res_hit_next;
        hit_dist_reg <= hit_dist_next;
        prod_reg     <= prod_next;
        point_reg    <= point_next;
        hit_reg          <= hit_next;
        cell_x_reg       <= cell_x_next;
        cell_y_reg       <= cell_y_next;
        cell_z_reg       <= cell_z_next;
        hit_distance_reg <= hit_distance_next;
        point_x_reg      <= point_x_next;
        point_y_reg      <= point_y_next;
        point_z_reg      <= point_z_next;
        entry_face_reg   <= entry_face_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= grid_mem[mem_raddr];
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign cell_x       = cell_x_reg;
    assign cell_y       = cell_y_reg;
    assign cell_z       = cell_z_reg;
    assign hit_distance = hit_distance_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign point_z      = point_z_reg;
    assign entry_face   = entry_face_reg;

endmodule
`default_nettype wire

>>> sv/voxel_ray_traversal_unit.sv
`default_nettype none
// Voxel ray caster over a cubic occupancy grid of 2^GRID_AXIS_BITS voxels per axis.
// After reset the grid is swept clear, one voxel a cycle; no request is accepted until
// the sweep ends. Requests enter a two-deep queue, so the input side keeps accepting
// while a cast is traced, until the queue is full. A write is done in the back end's
// idle state and returns nothing. A cast returns one result: the square root gives one
// bit a cycle, the nine divisions share one divider that yields one quotient bit a
// cycle, and each cell costs one grid read and one step. A direction whose squared
// length is below three, with at most two unit components, is answered as a miss
// without a trace.
module voxel_ray_traversal_unit #(
    parameter int GRID_AXIS_BITS = vrt_pkg::GRID_AXIS_BITS_DEF,
    parameter int FRACTION_BITS  = vrt_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic [vrt_pkg::VOXEL_W-1:0]        voxel_x,
    input  wire logic [vrt_pkg::VOXEL_W-1:0]        voxel_y,
    input  wire logic [vrt_pkg::VOXEL_W-1:0]        voxel_z,
    input  wire logic                               voxel_solid,
    input  wire logic signed [vrt_pkg::ORIGIN_W-1:0] origin_x,
    input  wire logic signed [vrt_pkg::ORIGIN_W-1:0] origin_y,
    input  wire logic signed [vrt_pkg::ORIGIN_W-1:0] origin_z,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]   dir_x,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]   dir_y,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]   dir_z,
    input  wire logic [vrt_pkg::DIST_W-1:0]         max_distance,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    hit,
    output logic signed [vrt_pkg::CELL_OUT_W-1:0]   cell_x,
    output logic signed [vrt_pkg::CELL_OUT_W-1:0]   cell_y,
    output logic signed [vrt_pkg::CELL_OUT_W-1:0]   cell_z,
    output logic [vrt_pkg::DIST_W-1:0]              hit_distance,
    output logic signed [vrt_pkg::ORIGIN_W-1:0]     point_x,
    output logic signed [vrt_pkg::ORIGIN_W-1:0]     point_y,
    output logic signed [vrt_pkg::ORIGIN_W-1:0]     point_z,
    output logic [vrt_pkg::FACE_W-1:0]              entry_face
);
    import vrt_pkg::*;

    logic       clearing;
    logic       q_full;
    logic       q_empty;
    logic       push;
    logic       pop;
    item_t      push_item;
    item_t      head_item;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    vrt_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .voxel_x      (voxel_x),
        .voxel_y      (voxel_y),
        .voxel_z      (voxel_z),
        .voxel_solid  (voxel_solid),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .origin_z     (origin_z),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .max_distance (max_distance),
        .clearing     (clearing),
        .q_full       (q_full),
        .push         (push),
        .item         (push_item)
    );

    vrt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (push_item),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .item_out (head_item)
    );

    vrt_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    vrt_back #(
        .GRID_AXIS_BITS (GRID_AXIS_BITS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (head_item),
        .q_pop        (pop),
        .clearing     (clearing),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .hit_distance (hit_distance),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .entry_face   (entry_face)
    );

endmodule
`default_nettype wire

>>> sv/vrt_checker.sv
`default_nettype none
module vrt_checker #(
    parameter int GRID_AXIS_BITS = vrt_pkg::GRID_AXIS_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic                               hit,
    input  wire logic signed [vrt_pkg::CELL_OUT_W-1:0] cell_x,
    input  wire logic signed [vrt_pkg::CELL_OUT_W-1:0] cell_y,
    input  wire logic signed [vrt_pkg::CELL_OUT_W-1:0] cell_z,
    input  wire logic [vrt_pkg::DIST_W-1:0]         hit_distance,
    input  wire logic signed [vrt_pkg::ORIGIN_W-1:0] point_x,
    input  wire logic signed [vrt_pkg::ORIGIN_W-1:0] point_y,
    input  wire logic signed [vrt_pkg::ORIGIN_W-1:0] point_z,
    input  wire logic [vrt_pkg::FACE_W-1:0]         entry_face
);
    import vrt_pkg::*;

    localparam int SIZE = 1 << GRID_AXIS_BITS;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hit) && $stable(hit_distance)
                                   && $stable(entry_face))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cell_x == 0 && cell_y == 0 && cell_z == 0
                              && hit_distance == 0 && point_x == 0 && point_y == 0
                              && point_z == 0 && entry_face == 0)
        else $error("miss carries non-zero fields");

    a_hit_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> cell_x >= 0 && cell_x < SIZE && cell_y >= 0 && cell_y < SIZE
                             && cell_z >= 0 && cell_z < SIZE && entry_face <= 3'd5)
        else $error("hit outside grid or bad face");

endmodule

bind voxel_ray_traversal_unit vrt_checker #(
    .GRID_AXIS_BITS (GRID_AXIS_BITS)
) u_vrt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_z       (cell_z),
    .hit_distance (hit_distance),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .entry_face   (entry_face)
);
`default_nettype wire
